[rtl/amf3_pkg.sv]
// Shared types and constants for the AMF3 number encoder.
`default_nettype none
package amf3_pkg;
   localparam logic [7:0] MARKER_INTEGER = 8'h04;
   localparam logic [7:0] MARKER_DOUBLE  = 8'h05;
   localparam logic       OP_NUMBER      = 1'b0;
   localparam logic       OP_HEADER      = 1'b1;
   localparam int         MAX_BYTES      = 9;

   typedef struct packed {
      logic        operation;
      logic [63:0] value_bits;
      logic [28:0] count;
      logic        is_reference;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rsp_type;

   // encoded burst of one item, bytes in send order from index 0
   typedef struct packed {
      logic [8:0][7:0] bytes;
      logic [3:0]      len;
      logic            error;
   } burst_type;
endpackage
`default_nettype wire

[rtl/amf3_if.sv]
// Valid/ready channel interface.
`default_nettype none
interface amf3_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/amf3_classify.sv]
// Stage 1: decide integral range and form the 29-bit value.
`default_nettype none
module amf3_classify (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire amf3_pkg::req_type in_item,
   output logic                   out_valid,
   output logic                   out_is_int,
   output logic                   out_is_hdr,
   output logic                   out_error,
   output logic [28:0]            out_u29,
   output logic [63:0]            out_bits
);
   import amf3_pkg::*;
   logic        valid_ff, is_int_ff, is_hdr_ff, error_ff;
   logic [28:0] u29_ff, u29_in;
   logic [63:0] bits_ff;
   logic        is_int_in;
   logic [10:0] ex;
   logic [51:0] mant, mask;
   logic [5:0]  sh;
   logic [52:0] mag;
   logic [28:0] mag29;

   always_comb begin
      ex = in_item.value_bits[62:52];
      mant = in_item.value_bits[51:0];
      sh = 6'd0;
      mask = '0;
      mag = '0;
      mag29 = '0;
      is_int_in = 1'b0;
      u29_in = '0;
      if (ex == 11'd0 && mant == 52'd0) begin
         is_int_in = 1'b1;
      end else if (ex >= 11'd1023 && ex < 11'd1051) begin
         sh = 6'(11'd1075 - ex);
         mask = ~(52'hf_ffff_ffff_ffff << sh);
         mag = {1'b1, mant} >> sh;
         mag29 = mag[28:0];
         is_int_in = (mant & mask) == 52'd0;
         u29_in = in_item.value_bits[63] ? 29'(0 - mag29) : mag29;
      end else if (ex == 11'd1051 && mant == 52'd0 && in_item.value_bits[63]) begin
         is_int_in = 1'b1;
         u29_in = 29'h1000_0000;
      end
      if (in_item.operation == OP_HEADER)
         u29_in = {in_item.count[27:0], ~in_item.is_reference};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
      if (adv) begin
         is_int_ff <= is_int_in;
         is_hdr_ff <= in_item.operation == OP_HEADER;
         error_ff  <= in_item.operation == OP_HEADER && in_item.count[28];
         u29_ff    <= u29_in;
         bits_ff   <= in_item.value_bits;
      end
   end
   assign out_valid = valid_ff;
   assign out_is_int = is_int_ff;
   assign out_is_hdr = is_hdr_ff;
   assign out_error = error_ff;
   assign out_u29 = u29_ff;
   assign out_bits = bits_ff;
endmodule
`default_nettype wire

[rtl/amf3_pack.sv]
// Stage 2: lay out the burst of bytes for one item.
`default_nettype none
module amf3_pack (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire logic         in_valid,
   input  wire logic         in_is_int,
   input  wire logic         in_is_hdr,
   input  wire logic         in_error,
   input  wire logic [28:0]  in_u29,
   input  wire logic [63:0]  in_bits,
   output logic              out_valid,
   output amf3_pkg::burst_type out_burst
);
   import amf3_pkg::*;
   logic      valid_ff;
   burst_type burst_ff, burst_in;
   logic [8:0][7:0] u;
   logic [2:0] ulen;

   always_comb begin
      u = '0;
      if (in_u29 < 29'h80) begin
         u[0] = {1'b0, in_u29[6:0]}; ulen = 3'd1;
      end else if (in_u29 < 29'h4000) begin
         u[0] = {1'b1, in_u29[13:7]}; u[1] = {1'b0, in_u29[6:0]}; ulen = 3'd2;
      end else if (in_u29 < 29'h20_0000) begin
         u[0] = {1'b1, in_u29[20:14]}; u[1] = {1'b1, in_u29[13:7]};
         u[2] = {1'b0, in_u29[6:0]}; ulen = 3'd3;
      end else begin
         u[0] = {1'b1, in_u29[28:22]}; u[1] = {1'b1, in_u29[21:15]};
         u[2] = {1'b1, in_u29[14:8]}; u[3] = in_u29[7:0]; ulen = 3'd4;
      end
      burst_in = '0;
      if (in_is_hdr) begin
         if (in_error) begin
            burst_in.len = 4'd1; burst_in.error = 1'b1;
         end else begin
            burst_in.bytes = u; burst_in.len = {1'b0, ulen};
         end
      end else if (in_is_int) begin
         burst_in.bytes = {u[7:0], MARKER_INTEGER};
         burst_in.len = {1'b0, ulen} + 4'd1;
      end else begin
         for (int i = 0; i < 8; i++) burst_in.bytes[i + 1] = in_bits[8 * (7 - i) +: 8];
         burst_in.bytes[0] = MARKER_DOUBLE;
         burst_in.len = 4'd9;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
      if (adv) burst_ff <= burst_in;
   end
   assign out_valid = valid_ff;
   assign out_burst = burst_ff;
endmodule
`default_nettype wire

[rtl/amf3_serialize.sv]
// Stage 3: shift the burst out one word at a time.
`default_nettype none
module amf3_serialize (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire amf3_pkg::burst_type in_burst,
   output logic                     in_ready,
   amf3_if.source                   rsp
);
   import amf3_pkg::*;
   logic       busy_ff;
   logic [3:0] idx_ff;
   burst_type  hold_ff;
   logic       fin;

   assign fin = busy_ff && rsp.ready && (idx_ff + 4'd1 == hold_ff.len);
   assign in_ready = !busy_ff || fin;
   assign rsp.valid = busy_ff;
   assign rsp.data.out_byte = hold_ff.bytes[idx_ff];
   assign rsp.data.last = idx_ff + 4'd1 == hold_ff.len;
   assign rsp.data.error = hold_ff.error;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else if (in_ready) begin
         busy_ff <= in_valid;
         idx_ff <= '0;
      end else if (rsp.ready) begin
         idx_ff <= idx_ff + 4'd1;
      end
      if (in_ready) hold_ff <= in_burst;
   end
endmodule
`default_nettype wire

[rtl/amf3_number_encoder_unit.sv]
// Top level of the AMF3 number and header encoder.
//  channel | dir | payload
//  req     | in  | operation, value_bits, count, is_reference
//  rsp     | out | out_byte, last, error (one word per cycle while ready)
// Two pipeline stages classify and pack; a third shifts 1 to 9 words out.
// Each item is 1 to 9 words long; the rsp port can stall its words.
// An item passes the classify, pack and serialize registers to its first word.
// Reset clears all valid bits; stalls on rsp hold every occupied stage in place.
`default_nettype none
module amf3_number_encoder_unit (
   input wire logic clock,
   input wire logic reset,
   amf3_if.sink     req,
   amf3_if.source   rsp
);
   import amf3_pkg::*;
   logic        v1, v2, i1, h1, e1, ser_ready, adv1, adv2;
   logic [28:0] u1;
   logic [63:0] b1;
   burst_type   bu2;

   assign adv2 = ser_ready || !v2;
   assign adv1 = adv2 || !v1;
   assign req.ready = adv1;

   amf3_classify u_cls (.clock, .reset, .adv(adv1), .in_valid(req.valid),
      .in_item(req.data), .out_valid(v1), .out_is_int(i1), .out_is_hdr(h1),
      .out_error(e1), .out_u29(u1), .out_bits(b1));
   amf3_pack u_pack (.clock, .reset, .adv(adv2), .in_valid(v1), .in_is_int(i1),
      .in_is_hdr(h1), .in_error(e1), .in_u29(u1), .in_bits(b1),
      .out_valid(v2), .out_burst(bu2));
   amf3_serialize u_ser (.clock, .reset, .in_valid(v2), .in_burst(bu2),
      .in_ready(ser_ready), .rsp(rsp));
endmodule
`default_nettype wire

[rtl/amf3_checker.sv]
// Port-level checks for the encoder, bound to the top level.
`default_nettype none
module amf3_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last,
   input wire logic rsp_error,
   input wire logic [7:0] rsp_byte
);
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && rsp_byte == 8'd0) else $error("error word");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("valid dropped");
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid) else $error("valid after reset");
endmodule
bind amf3_number_encoder_unit amf3_checker u_chk (.clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(rsp.data.last),
   .rsp_error(rsp.data.error), .rsp_byte(rsp.data.out_byte));
`default_nettype wire
